@@ rtl/core/uvs_pkg.sv @@
// Shared types and constants for the UV sphere strip generator.
// Holds the sequencer states, the vertex record and the CORDIC arctangent table.
// No dependencies.
package uvs_pkg;

    localparam int QUARTER_W     = 7;
    localparam int QUARTER_RESET = 5;
    localparam int RADIUS_W      = 16;
    localparam int RADIUS_RESET  = 256;
    localparam int CFG_W         = 16;
    localparam int NRM_W         = 16;
    localparam int POS_W         = 17;
    localparam int TEX_W         = 17;
    localparam int TDATA_W       = 136;
    localparam int QUO_W         = 31;
    localparam int CNT_W         = 5;
    localparam int XY_W          = 33;
    localparam int Z_W           = 34;
    localparam int PROD_W        = 34;

    localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;
    localparam logic [30:0] CORDIC_GAIN_Q30 = 31'd652032874;

    // Register indexes on the configuration port
    localparam logic REG_QUARTER = 1'b0;
    localparam logic REG_RADIUS  = 1'b1;

    typedef enum logic [3:0] {
        B_IDLE,
        B_ANG,
        B_ANGM,
        B_DIV,
        B_CINIT,
        B_ROT,
        B_TRIG,
        B_TEXS,
        B_TEXD,
        B_M0,
        B_M1,
        B_M2,
        B_M3,
        B_M4,
        B_M5,
        B_OUT
    } back_state_t;

    typedef enum logic [1:0] {
        PH_LON,
        PH_UP,
        PH_LOW
    } phase_t;

    typedef enum logic {
        DIV_ANGLE,
        DIV_TEX
    } div_kind_t;

    typedef struct packed {
        logic                     sphere_end;
        logic                     pair_end;
        logic [TEX_W-1:0]         tex_v;
        logic [TEX_W-1:0]         tex_u;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [NRM_W-1:0]  normal_z;
        logic signed [NRM_W-1:0]  normal_y;
        logic signed [NRM_W-1:0]  normal_x;
    } vtx_t;

    // atan(2^-i) in Q2.30 radians
    function automatic logic [30:0] atan_q30(input logic [CNT_W-1:0] i);
        logic [30:0] a;
        begin
            case (i)
                5'd0:    a = 31'd843314857;
                5'd1:    a = 31'd497837830;
                5'd2:    a = 31'd263043837;
                5'd3:    a = 31'd133525159;
                5'd4:    a = 31'd67021687;
                5'd5:    a = 31'd33543516;
                5'd6:    a = 31'd16775851;
                5'd7:    a = 31'd8388437;
                5'd8:    a = 31'd4194283;
                5'd9:    a = 31'd2097149;
                5'd10:   a = 31'd1048576;
                5'd11:   a = 31'd524288;
                5'd12:   a = 31'd262144;
                5'd13:   a = 31'd131072;
                5'd14:   a = 31'd65536;
                5'd15:   a = 31'd32768;
                5'd16:   a = 31'd16384;
                5'd17:   a = 31'd8192;
                5'd18:   a = 31'd4096;
                5'd19:   a = 31'd2048;
                5'd20:   a = 31'd1024;
                5'd21:   a = 31'd512;
                5'd22:   a = 31'd256;
                5'd23:   a = 31'd128;
                default: a = 31'd0;
            endcase
            return a;
        end
    endfunction

endpackage

@@ rtl/core/uvs_front.sv @@
// Front end: accepts requests, tracks ring and column, emits one job per request.
// Depends on uvs_pkg.
module uvs_front #(
    parameter int MAX_QUARTER = 64,
    parameter int QW          = 7,
    parameter int JW          = 3 * QW + 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [uvs_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic                          req_restart,
    output logic                          job_push,
    output logic [JW-1:0]                 job_data,
    input  logic                          job_full
);
    import uvs_pkg::*;

    localparam int RW    = QW + 1;
    localparam int CW    = QW + 2;
    localparam int RST_Q = (QUARTER_RESET > MAX_QUARTER) ? MAX_QUARTER : QUARTER_RESET;

    logic [QUARTER_W-1:0]  quarter_reg;
    logic signed [RW-1:0]  ring_reg, ring_next;
    logic [CW-1:0]         col_reg, col_next;
    logic [QW-1:0]         q_eff, q_new;
    logic signed [RW-1:0]  q_s;
    logic [CW-1:0]         n_w;
    logic signed [RW-1:0]  ring_use;
    logic [CW-1:0]         col_use;
    logic                  last_w;
    logic signed [RW-1:0]  ring_inc;

    function automatic logic [QW-1:0] eff_q(input logic [QUARTER_W-1:0] v);
        begin
            if (v == '0)
                eff_q = QW'(1);
            else if ({1'b0, v} > (QUARTER_W + 1)'(MAX_QUARTER))
                eff_q = QW'(MAX_QUARTER);
            else
                eff_q = QW'(v);
        end
    endfunction

    // Effective segment quarter and derived counts
    always_comb
    begin
        q_eff    = eff_q(quarter_reg);
        q_new    = eff_q(cfg_data[QUARTER_W-1:0]);
        q_s      = signed'({1'b0, q_eff});
        n_w      = {q_eff, 2'b00};
        ring_use = req_restart ? -q_s : ring_reg;
        col_use  = req_restart ? '0 : col_reg;
        last_w   = (ring_use == q_s - RW'(1)) && (col_use == n_w);
        ring_inc = ring_use + RW'(1);
        if (col_use == n_w)
        begin
            col_next  = '0;
            ring_next = (ring_inc >= q_s) ? -q_s : ring_inc;
        end
        else
        begin
            col_next  = col_use + CW'(1);
            ring_next = ring_use;
        end
    end

    assign req_ready = !job_full;
    assign job_push  = req_valid && !job_full;
    assign job_data  = {last_w, q_eff, col_use, ring_use};

    // Hold configuration and advance the strip position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quarter_reg <= QUARTER_W'(QUARTER_RESET);
            ring_reg    <= -RW'(RST_Q);
            col_reg     <= '0;
        end
        else if (cfg_we && cfg_index == REG_QUARTER)
        begin
            quarter_reg <= cfg_data[QUARTER_W-1:0];
            ring_reg    <= -signed'({1'b0, q_new});
            col_reg     <= '0;
        end
        else if (job_push)
        begin
            ring_reg <= ring_next;
            col_reg  <= col_next;
        end
    end

endmodule

@@ rtl/core/uvs_queue.sv @@
// Two-entry job queue between the front end and the vertex engine.
// Depends on uvs_pkg only through the modules around it.
module uvs_queue #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output logic [W-1:0] head
);
    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

@@ rtl/core/uvs_back.sv @@
// Vertex engine: shared divider, CORDIC and multiplier run one job into two vertices.
// Depends on uvs_pkg.
module uvs_back #(
    parameter int CORDIC_STEPS = 16,
    parameter int QW           = 7,
    parameter int JW           = 3 * QW + 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           job_valid,
    input  logic [JW-1:0]                  job_data,
    output logic                           job_pop,
    input  logic [uvs_pkg::RADIUS_W-1:0]   radius,
    output logic                           out_valid,
    input  logic                           out_ready,
    output uvs_pkg::vtx_t                  out_vtx
);
    import uvs_pkg::*;

    localparam int RW = QW + 1;
    localparam int CW = QW + 2;
    localparam int DW = QW + QUO_W;

    back_state_t state_reg, state_next;
    phase_t      phase_reg, phase_next;
    div_kind_t   kind_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Job fields
    logic signed [RW-1:0] ring_reg;
    logic [CW-1:0]        col_reg;
    logic [QW-1:0]        q_reg;
    logic                 last_reg;

    // Angle reduction
    logic [1:0]           quad_reg;
    logic [QW-1:0]        r_reg;

    // Divider
    logic [QW:0]          rem_reg;
    logic [QUO_W-1:0]     dvd_reg, quo_reg;
    logic [QW:0]          dvs_reg;

    // CORDIC
    logic signed [XY_W-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0]  z_reg;

    // Results
    logic signed [NRM_W-1:0] lc_reg, ls_reg, cl_reg, sl_reg, nx_reg, nz_reg;
    logic signed [POS_W-1:0] px_reg, py_reg, pz_reg;
    logic [TEX_W-1:0]        u_reg, v_reg;
    logic signed [PROD_W-1:0] p_reg;

    logic    out_valid_reg;
    vtx_t    out_reg;

    logic [CW-1:0]          n_w;
    logic signed [RW-1:0]   lat_w;
    logic signed [CW:0]     lat_x;
    logic [CW-1:0]          km_w, q1_w, q2_w, q3_w;
    logic [1:0]             quad_w;
    logic [QW-1:0]          r_w;
    logic [DW-1:0]          dsrc_w;
    logic [QW:0]            latq_w;
    logic [QW+1:0]          trial_w;
    logic signed [XY_W-1:0] dx_w, dy_w;
    logic signed [Z_W-1:0]  at_w;
    logic signed [XY_W-1:0] xr_w, yr_w;
    logic signed [NRM_W-1:0] cc_w, ss_w, c_w, s_w;
    logic signed [16:0]     ma_w, mb_w;
    logic signed [PROD_W-1:0] prod_w;
    logic signed [PROD_W-1:0] pr_w;
    logic signed [NRM_W-1:0] rn_w;
    logic signed [POS_W-1:0] rp_w;
    logic                    out_load;

    function automatic logic signed [NRM_W-1:0] clamp_nrm(input logic signed [XY_W-1:0] v);
        begin
            if (v > XY_W'(16384))
                clamp_nrm = NRM_W'(16384);
            else if (v < -XY_W'(16384))
                clamp_nrm = -NRM_W'(16384);
            else
                clamp_nrm = NRM_W'(v);
        end
    endfunction

    // Angle and texture operands
    always_comb
    begin
        n_w    = {q_reg, 2'b00};
        lat_w  = (phase_reg == PH_UP) ? ring_reg + RW'(1) : ring_reg;
        lat_x  = (CW + 1)'(lat_w);
        if (phase_reg == PH_LON)
            km_w = (col_reg == n_w) ? '0 : col_reg;
        else if (lat_x < 0)
            km_w = CW'(lat_x + signed'({1'b0, n_w}));
        else
            km_w = CW'(lat_x);
        q1_w = CW'(q_reg);
        q2_w = CW'({q_reg, 1'b0});
        q3_w = q1_w + q2_w;
        if (km_w >= q3_w)
        begin
            quad_w = 2'd3;
            r_w    = QW'(km_w - q3_w);
        end
        else if (km_w >= q2_w)
        begin
            quad_w = 2'd2;
            r_w    = QW'(km_w - q2_w);
        end
        else if (km_w >= q1_w)
        begin
            quad_w = 2'd1;
            r_w    = QW'(km_w - q1_w);
        end
        else
        begin
            quad_w = 2'd0;
            r_w    = QW'(km_w);
        end
        latq_w = (QW + 1)'(lat_w + signed'(RW'(q_reg)));
        if (state_reg == B_ANGM)
            dsrc_w = DW'(r_reg) * DW'(HALF_PI_Q30);
        else if (phase_reg == PH_LON)
            dsrc_w = DW'({col_reg, 15'b0}) + DW'(q_reg);
        else
            dsrc_w = DW'({latq_w, 16'b0}) + DW'(q_reg);
    end

    // Divider step, rotation step and rounding
    always_comb
    begin
        trial_w = {rem_reg, dvd_reg[QUO_W-1]} - {1'b0, dvs_reg};
        dx_w    = y_reg >>> cnt_reg;
        dy_w    = x_reg >>> cnt_reg;
        at_w    = Z_W'(atan_q30(cnt_reg));
        xr_w    = (x_reg + XY_W'(32768)) >>> 16;
        yr_w    = (y_reg + XY_W'(32768)) >>> 16;
        cc_w    = clamp_nrm(xr_w);
        ss_w    = clamp_nrm(yr_w);
        case (quad_reg)
            2'd0:
            begin
                c_w = cc_w;
                s_w = ss_w;
            end
            2'd1:
            begin
                c_w = -ss_w;
                s_w = cc_w;
            end
            2'd2:
            begin
                c_w = -cc_w;
                s_w = -ss_w;
            end
            default:
            begin
                c_w = ss_w;
                s_w = -cc_w;
            end
        endcase
        case (state_reg)
            B_M0:
            begin
                ma_w = 17'(cl_reg);
                mb_w = 17'(lc_reg);
            end
            B_M1:
            begin
                ma_w = 17'(cl_reg);
                mb_w = 17'(ls_reg);
            end
            B_M2:
            begin
                ma_w = signed'({1'b0, radius});
                mb_w = 17'(nx_reg);
            end
            B_M3:
            begin
                ma_w = signed'({1'b0, radius});
                mb_w = 17'(sl_reg);
            end
            default:
            begin
                ma_w = signed'({1'b0, radius});
                mb_w = 17'(nz_reg);
            end
        endcase
        prod_w = PROD_W'(ma_w) * PROD_W'(mb_w);
        pr_w   = (p_reg + PROD_W'(8192)) >>> 14;
        if (pr_w > PROD_W'(16384))
            rn_w = NRM_W'(16384);
        else if (pr_w < -PROD_W'(16384))
            rn_w = -NRM_W'(16384);
        else
            rn_w = NRM_W'(pr_w);
        if (pr_w > PROD_W'(65535))
            rp_w = POS_W'(65535);
        else if (pr_w < -PROD_W'(65535))
            rp_w = -POS_W'(65535);
        else
            rp_w = POS_W'(pr_w);
    end

    assign out_load = !out_valid_reg || out_ready;

    // Sequencer: next state and handshakes
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        job_pop    = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    phase_next = PH_LON;
                    state_next = B_ANG;
                end
            end
            B_ANG:   state_next = B_ANGM;
            B_ANGM:
            begin
                cnt_next   = '0;
                state_next = B_DIV;
            end
            B_DIV:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QUO_W - 1))
                    state_next = (kind_reg == DIV_ANGLE) ? B_CINIT : B_TEXD;
            end
            B_CINIT:
            begin
                cnt_next   = '0;
                state_next = B_ROT;
            end
            B_ROT:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                    state_next = B_TRIG;
            end
            B_TRIG:  state_next = B_TEXS;
            B_TEXS:
            begin
                cnt_next   = '0;
                state_next = B_DIV;
            end
            B_TEXD:
            begin
                if (phase_reg == PH_LON)
                begin
                    phase_next = PH_UP;
                    state_next = B_ANG;
                end
                else
                    state_next = B_M0;
            end
            B_M0:    state_next = B_M1;
            B_M1:    state_next = B_M2;
            B_M2:    state_next = B_M3;
            B_M3:    state_next = B_M4;
            B_M4:    state_next = B_M5;
            B_M5:    state_next = B_OUT;
            B_OUT:
            begin
                if (out_load)
                begin
                    if (phase_reg == PH_UP)
                    begin
                        phase_next = PH_LOW;
                        state_next = B_ANG;
                    end
                    else
                        state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            phase_reg     <= PH_LON;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            if (state_reg == B_OUT && out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                ring_reg <= job_data[RW-1:0];
                col_reg  <= job_data[RW+CW-1:RW];
                q_reg    <= job_data[RW+CW+QW-1:RW+CW];
                last_reg <= job_data[JW-1];
            end
            B_ANG:
            begin
                quad_reg <= quad_w;
                r_reg    <= r_w;
            end
            B_ANGM:
            begin
                kind_reg <= DIV_ANGLE;
                rem_reg  <= {1'b0, dsrc_w[DW-1:QUO_W]};
                dvd_reg  <= dsrc_w[QUO_W-1:0];
                dvs_reg  <= {1'b0, q_reg};
            end
            B_TEXS:
            begin
                kind_reg <= DIV_TEX;
                rem_reg  <= {1'b0, dsrc_w[DW-1:QUO_W]};
                dvd_reg  <= dsrc_w[QUO_W-1:0];
                dvs_reg  <= {q_reg, 1'b0};
            end
            B_DIV:
            begin
                dvd_reg <= {dvd_reg[QUO_W-2:0], 1'b0};
                if (!trial_w[QW+1])
                begin
                    rem_reg <= trial_w[QW:0];
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[QW-1:0], dvd_reg[QUO_W-1]};
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
                end
            end
            B_CINIT:
            begin
                x_reg <= XY_W'(CORDIC_GAIN_Q30);
                y_reg <= '0;
                z_reg <= Z_W'(quo_reg);
            end
            B_ROT:
            begin
                if (!z_reg[Z_W-1])
                begin
                    x_reg <= x_reg - dx_w;
                    y_reg <= y_reg + dy_w;
                    z_reg <= z_reg - at_w;
                end
                else
                begin
                    x_reg <= x_reg + dx_w;
                    y_reg <= y_reg - dy_w;
                    z_reg <= z_reg + at_w;
                end
            end
            B_TRIG:
            begin
                if (phase_reg == PH_LON)
                begin
                    lc_reg <= c_w;
                    ls_reg <= s_w;
                end
                else
                begin
                    cl_reg <= c_w;
                    sl_reg <= s_w;
                end
            end
            B_TEXD:
            begin
                if (phase_reg == PH_LON)
                    u_reg <= (quo_reg >= QUO_W'(65536)) ? '0
                             : TEX_W'(65536) - TEX_W'(quo_reg);
                else
                    v_reg <= (quo_reg > QUO_W'(65536)) ? TEX_W'(65536) : TEX_W'(quo_reg);
            end
            B_M0:
                p_reg <= prod_w;
            B_M1:
            begin
                nx_reg <= rn_w;
                p_reg  <= prod_w;
            end
            B_M2:
            begin
                nz_reg <= rn_w;
                p_reg  <= prod_w;
            end
            B_M3:
            begin
                px_reg <= rp_w;
                p_reg  <= prod_w;
            end
            B_M4:
            begin
                py_reg <= rp_w;
                p_reg  <= prod_w;
            end
            B_M5:
            begin
                pz_reg <= rp_w;
            end
            B_OUT:
            begin
                if (out_load)
                begin
                    out_reg.normal_x   <= nx_reg;
                    out_reg.normal_y   <= sl_reg;
                    out_reg.normal_z   <= nz_reg;
                    out_reg.pos_x      <= px_reg;
                    out_reg.pos_y      <= py_reg;
                    out_reg.pos_z      <= pz_reg;
                    out_reg.tex_u      <= u_reg;
                    out_reg.tex_v      <= v_reg;
                    out_reg.pair_end   <= (phase_reg == PH_LOW);
                    out_reg.sphere_end <= (phase_reg == PH_LOW) && last_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_vtx   = out_reg;

endmodule

@@ rtl/core/uv_sphere_strip_generator_core.sv @@
// Top level of the UV sphere strip generator: front end, job queue, vertex engine.
// Depends on uvs_pkg, uvs_front, uvs_queue and uvs_back.
//
//  Channel   Direction  Handshake           Payload
//  s_*       in         s_tvalid/s_tready   s_tdata[0] restart
//  m_*       out        m_tvalid/m_tready   m_tdata vertex, m_tuser pair_end, m_tlast sphere_end
//  cfg_*     in         cfg_we              cfg_index register, cfg_data value
//
// One request yields two vertices; six runs of the shared restoring divider and
// three CORDIC rotations of CORDIC_STEPS steps each dominate the work.
// Reset is asynchronous and active low; no clearing pass is needed.
// A two-entry job queue lets requests be taken while the engine works, and the
// output register lets the engine finish a vertex while the previous one waits.
module uv_sphere_strip_generator_core #(
    parameter int MAX_QUARTER  = 64,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [0] restart
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // normal_x, normal_y, normal_z, pos_x, pos_y, pos_z, tex_u, tex_v, zero pad
    output logic [uvs_pkg::TDATA_W-1:0]         m_tdata,
    output logic                                m_tuser,   // [0] pair_end
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [uvs_pkg::CFG_W-1:0]           cfg_data
);
    import uvs_pkg::*;

    localparam int QW = $clog2(MAX_QUARTER + 1);
    localparam int JW = 3 * QW + 4;

    logic [RADIUS_W-1:0] radius_reg;
    logic                job_push, job_full, job_pop, job_valid;
    logic [JW-1:0]       job_in, job_head;
    vtx_t                vtx;

    // Hold the radius register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RADIUS_W'(RADIUS_RESET);
        else if (cfg_we && cfg_index == REG_RADIUS)
            radius_reg <= cfg_data[RADIUS_W-1:0];
    end

    uvs_front #(
        .MAX_QUARTER (MAX_QUARTER),
        .QW          (QW),
        .JW          (JW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_restart (s_tdata[0]),
        .job_push    (job_push),
        .job_data    (job_in),
        .job_full    (job_full)
    );

    uvs_queue #(
        .W (JW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .not_empty (job_valid),
        .head      (job_head)
    );

    uvs_back #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .QW           (QW),
        .JW           (JW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_data  (job_head),
        .job_pop   (job_pop),
        .radius    (radius_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_vtx   (vtx)
    );

    // Pack the vertex word
    assign m_tdata = {3'b000, vtx.tex_v, vtx.tex_u, vtx.pos_z, vtx.pos_y, vtx.pos_x,
                      vtx.normal_z, vtx.normal_y, vtx.normal_x};
    assign m_tuser = vtx.pair_end;
    assign m_tlast = vtx.sphere_end;

endmodule

@@ verif/uv_sphere_strip_generator_core_tb.sv @@
// Testbench for the UV sphere strip generator core: directed and random requests.
// Depends on uvs_pkg and uv_sphere_strip_generator_core; predicts each vertex pair itself.
`timescale 1ns / 1ps

module uv_sphere_strip_generator_core_tb;
    import uvs_pkg::*;

    localparam int STEPS      = 16;
    localparam int MAXQ       = 64;
    localparam int QUIET_MAX  = 20000;
    localparam int SETTLE     = 400;

    localparam longint ATAN_TAB [16] = '{
        843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768
    };

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // Predictor state
    logic [QUARTER_W-1:0] quarter_reg;
    logic [RADIUS_W-1:0]  radius_reg;
    int                   ring_at;
    int                   col_at;

    vtx_t                 vertex_q[$];
    int                   errors;
    int                   words_in;
    int                   words_out;
    int                   sphere_ends;
    int                   quiet_cycles;
    int                   send_idle_pct;
    int                   stall_pct;
    int                   holdoff_left;

    uv_sphere_strip_generator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int active_quarter();
        if (quarter_reg == 0)
            return 1;
        if (quarter_reg > MAXQ)
            return MAXQ;
        return int'(quarter_reg);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Cosine and sine of k/(4q) turn in Q1.14
    function automatic void sincos(input int k, input int q, output longint c,
                                   output longint s);
        int     n;
        int     km;
        int     quad;
        int     r;
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        longint cc;
        longint ss;
        n  = 4 * q;
        km = k % n;
        if (km < 0)
            km += n;
        quad = km / q;
        r    = km % q;
        z    = (longint'(r) * 64'sd1686629713) / q;
        x    = 64'sd652032874;
        y    = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end
            else
            begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end
        end
        cc = clip((x + 32768) >>> 16, -16384, 16384);
        ss = clip((y + 32768) >>> 16, -16384, 16384);
        case (quad)
            0:       begin c = cc;  s = ss;  end
            1:       begin c = -ss; s = cc;  end
            2:       begin c = -cc; s = -ss; end
            default: begin c = ss;  s = -cc; end
        endcase
    endfunction

    function automatic vtx_t make_vertex(int lat, int q, longint lc, longint ls,
                                         longint u, logic lower, logic last);
        vtx_t   v;
        longint cl;
        longint sl;
        longint nx;
        longint nz;
        longint rad;
        longint tv;
        longint px;
        longint py;
        longint pz;
        sincos(lat, q, cl, sl);
        nx  = clip((cl * lc + 8192) >>> 14, -16384, 16384);
        nz  = clip((cl * ls + 8192) >>> 14, -16384, 16384);
        rad = longint'(radius_reg);
        px  = clip((rad * nx + 8192) >>> 14, -65535, 65535);
        py  = clip((rad * sl + 8192) >>> 14, -65535, 65535);
        pz  = clip((rad * nz + 8192) >>> 14, -65535, 65535);
        tv  = (2 * (longint'(lat + q) * 32768) + q) / (2 * q);
        if (tv > 65536)
            tv = 65536;
        v.normal_x   = nx[NRM_W-1:0];
        v.normal_y   = sl[NRM_W-1:0];
        v.normal_z   = nz[NRM_W-1:0];
        v.pos_x      = px[POS_W-1:0];
        v.pos_y      = py[POS_W-1:0];
        v.pos_z      = pz[POS_W-1:0];
        v.tex_u      = u[TEX_W-1:0];
        v.tex_v      = tv[TEX_W-1:0];
        v.pair_end   = lower;
        v.sphere_end = last;
        return v;
    endfunction

    // Advance the strip position and queue the upper and lower vertex
    task automatic predict_pair(input logic restart);
        int     q;
        int     n;
        int     ring;
        int     col;
        longint lc;
        longint ls;
        longint frac;
        longint u;
        q = active_quarter();
        n = 4 * q;
        if (restart || ring_at < -q || ring_at >= q || col_at < 0 || col_at > n)
        begin
            ring_at = -q;
            col_at  = 0;
        end
        ring = ring_at;
        col  = col_at;
        sincos(col == n ? 0 : col, q, lc, ls);
        frac = (longint'(col) * 32768 + q) / (2 * q);
        u    = frac >= 65536 ? 0 : 65536 - frac;
        vertex_q.push_back(make_vertex(ring + 1, q, lc, ls, u, 1'b0, 1'b0));
        vertex_q.push_back(make_vertex(ring, q, lc, ls, u, 1'b1,
                                       ring == q - 1 && col == n));
        col_at = col + 1;
        if (col_at > n)
        begin
            col_at  = 0;
            ring_at = ring + 1;
            if (ring_at >= q)
                ring_at = -q;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Check every vertex word against the oldest prediction
    always @(posedge clk)
    begin
        vtx_t got;
        vtx_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tlast, m_tuser, m_tdata[132:0]};
            words_out++;
            if (got.sphere_end)
                sphere_ends++;
            if (vertex_q.size() == 0)
                report_mismatch("unexpected vertex", 1, 0);
            else
            begin
                want = vertex_q.pop_front();
                if (got.normal_x !== want.normal_x)
                    report_mismatch("normal_x", got.normal_x, want.normal_x);
                if (got.normal_y !== want.normal_y)
                    report_mismatch("normal_y", got.normal_y, want.normal_y);
                if (got.normal_z !== want.normal_z)
                    report_mismatch("normal_z", got.normal_z, want.normal_z);
                if (got.pos_x !== want.pos_x)
                    report_mismatch("pos_x", got.pos_x, want.pos_x);
                if (got.pos_y !== want.pos_y)
                    report_mismatch("pos_y", got.pos_y, want.pos_y);
                if (got.pos_z !== want.pos_z)
                    report_mismatch("pos_z", got.pos_z, want.pos_z);
                if (got.tex_u !== want.tex_u)
                    report_mismatch("tex_u", got.tex_u, want.tex_u);
                if (got.tex_v !== want.tex_v)
                    report_mismatch("tex_v", got.tex_v, want.tex_v);
                if (got.pair_end !== want.pair_end)
                    report_mismatch("pair_end", got.pair_end, want.pair_end);
                if (got.sphere_end !== want.sphere_end)
                    report_mismatch("sphere_end", got.sphere_end, want.sphere_end);
            end
        end
    end

    // Drive receiver readiness; a hold-off keeps it low
    always @(negedge clk)
    begin
        if (holdoff_left > 0)
        begin
            m_tready = 1'b0;
            holdoff_left--;
        end
        else
            m_tready = ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_MAX)
        begin
            $display("Timeout after %0d quiet cycles", quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one request word, with a random idle gap first
    task automatic send_request(input logic restart);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 200)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {7'($urandom), restart};
        do
            @(posedge clk);
        while (!s_tready);
        words_in++;
        predict_pair(restart);
    endtask

    // Drop valid and hold until every vertex has come out
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        wait (vertex_q.size() == 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_data  = CFG_W'($urandom);
        if (idx == REG_QUARTER)
        begin
            quarter_reg = value[QUARTER_W-1:0];
            ring_at     = -active_quarter();
            col_at      = 0;
        end
        else
            radius_reg = value;
    endtask

    task automatic test_reset_state();
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        drain();
    endtask

    // Smallest sphere: walk both rings, hit the end and wrap
    task automatic test_small_sphere();
        write_reg(REG_QUARTER, 16'd1);
        for (int i = 0; i < 12; i++)
            send_request(1'b0);
        drain();
    endtask

    task automatic test_extremes();
        write_reg(REG_QUARTER, 16'd64);
        write_reg(REG_RADIUS, 16'hFFFF);
        send_request(1'b0);
        send_request(1'b0);
        drain();
        write_reg(REG_QUARTER, 16'd0);
        write_reg(REG_RADIUS, 16'd0);
        send_request(1'b0);
        send_request(1'b1);
        drain();
        write_reg(REG_QUARTER, 16'hFF7F);
        write_reg(REG_RADIUS, 16'h8000);
        send_request(1'b1);
        send_request(1'b0);
        drain();
        write_reg(REG_QUARTER, 16'h0002);
        write_reg(REG_RADIUS, 16'h7FFF);
        send_request(1'b0);
        send_request(1'b0);
        drain();
    endtask

    task automatic random_settings();
        logic [CFG_W-1:0] qv;
        if ($urandom_range(9) < 8)
            qv = {9'($urandom), 7'($urandom_range(1, 6))};
        else
            qv = CFG_W'($urandom);
        write_reg(REG_QUARTER, qv);
        write_reg(REG_RADIUS, CFG_W'($urandom));
    endtask

    // Mostly continuing strips, with occasional restarts
    task automatic test_random_phase(input int idle_pct, input int stall, input int count);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 0)
            begin
                drain();
                random_settings();
            end
            send_request($urandom_range(99) < 5);
        end
        drain();
    endtask

    // Long receiver hold-off fills the queue and stalls the input
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        @(negedge clk);
        holdoff_left = 3000;
        for (int i = 0; i < 8; i++)
            send_request(1'b0);
        drain();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_QUARTER;
        cfg_data      = '0;
        quarter_reg   = QUARTER_RESET;
        radius_reg    = RADIUS_RESET;
        ring_at       = -QUARTER_RESET;
        col_at        = 0;
        errors        = 0;
        words_in      = 0;
        words_out     = 0;
        sphere_ends   = 0;
        quiet_cycles  = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        holdoff_left  = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_small_sphere();
        test_extremes();
        test_random_phase(0, 0, 250);
        test_random_phase(81, 0, 250);
        test_random_phase(0, 81, 250);
        test_random_phase(29, 29, 250);
        test_backpressure();

        $display("Covered %0d requests and %0d vertices, %0d sphere ends, across",
                 words_in, words_out, sphere_ends);
        $display("reset, extreme and random settings, idle and stall phases, long backpressure");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/uvs_pkg.sv
rtl/core/uvs_front.sv
rtl/core/uvs_queue.sv
rtl/core/uvs_back.sv
rtl/core/uv_sphere_strip_generator_core.sv
verif/uv_sphere_strip_generator_core_tb.sv
